>>> sv/udpd_pkg.sv
// udpd_pkg: shared types and constants for the UDP port demultiplexer table.
// Used by udpd_ctrl, udpd_dp and udp_port_demux_table; no dependencies.
package udpd_pkg;

    localparam int SLOTS = 16;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [15:0] EPH_FIRST_RST = 16'd600;
    localparam logic [15:0] EPH_END_RST   = 16'd1024;

    typedef enum logic [2:0] {
        REQ_OPEN    = 3'd0,
        REQ_CLOSE   = 3'd1,
        REQ_BIND    = 3'd2,
        REQ_CONNECT = 3'd3,
        REQ_LISTEN  = 3'd4,
        REQ_RECV    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_NOMATCH  = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    localparam int CFG_FIRST = 0;
    localparam int CFG_END   = 1;

    localparam logic [2:0] MODE_INIT   = 3'b001;
    localparam logic [2:0] MODE_CONN   = 3'b010;
    localparam logic [2:0] MODE_LISTEN = 3'b100;

    // controller commands to datapath
    typedef struct packed {
        logic load;        // capture request
        logic scan_clr;    // restart slot scan
        logic scan_step;   // advance scan index
        logic cand_init;   // load candidate from counter (wrapped)
        logic cand_step;   // advance candidate
        logic use_req;     // candidate is requested port
        logic commit;      // apply request outcome
        logic fail_bind;   // bind failed
        logic recv_hit;    // record receive match
        logic recv_miss;   // no match
        logic ignore;      // ignored request
        logic refuse_open; // open of an open slot
    } cmd_t;

    // datapath status to controller
    typedef struct packed {
        logic [2:0] req;
        logic       slot_ok;
        logic       tgt_open;
        logic       tgt_init;
        logic       scan_last;
        logic       scan_hit;  // current scan slot matches
        logic       cand_zero;
        logic       cand_back; // next candidate returns to start
    } stat_t;

endpackage

>>> sv/udp_port_demux_table.sv
// udp_port_demux_table: top level of the UDP endpoint slot table.
// Depends on udpd_pkg, udpd_ctrl and udpd_dp.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | req_type slot local_port remote_port remote_addr local_addr
//  out     | out_valid/out_ready| status hit_slot reply_sent bound_port peer_port peer_addr
//          |                    | pass_source
//  cfg     | cfg_we             | cfg_index cfg_data
//
// A request is either decoded alone or runs a receive scan over the slots; a bind with its
// own port is checked by a scan of the slots, using the single-slot compare of the scan.
// A picked port loads a candidate from the allocation counter and rescans per candidate tried.
// Reset is asynchronous and clears the whole table at once.
// A new request is taken only after the previous result has left the output register.
module udp_port_demux_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  slot,
    input  logic [15:0] local_port,
    input  logic [15:0] remote_port,
    input  logic [31:0] remote_addr,
    input  logic [31:0] local_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  hit_slot,
    output logic        reply_sent,
    output logic [15:0] bound_port,
    output logic [15:0] peer_port,
    output logic [31:0] peer_addr,
    output logic        pass_source
);
    import udpd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    udpd_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
    );

    udpd_dp u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .req_type, .slot, .local_port, .remote_port, .remote_addr, .local_addr,
        .cmd, .stat, .status, .hit_slot, .reply_sent, .bound_port, .peer_port,
        .peer_addr, .pass_source
    );

endmodule

>>> sv/udpd_dp.sv
// udpd_dp: slot table, scan index, allocation counter and result register.
// Depends on udpd_pkg.
module udpd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [2:0]           req_type,
    input  logic [3:0]           slot,
    input  logic [15:0]          local_port,
    input  logic [15:0]          remote_port,
    input  logic [31:0]          remote_addr,
    input  logic [31:0]          local_addr,
    input  udpd_pkg::cmd_t       cmd,
    output udpd_pkg::stat_t      stat,
    output logic [1:0]           status,
    output logic [3:0]           hit_slot,
    output logic                 reply_sent,
    output logic [15:0]          bound_port,
    output logic [15:0]          peer_port,
    output logic [31:0]          peer_addr,
    output logic                 pass_source
);
    import udpd_pkg::*;

    logic [SLOTS-1:0] open_reg;
    logic [2:0]       mode_reg   [SLOTS];
    logic [15:0]      lport_reg  [SLOTS];
    logic [15:0]      pport_reg  [SLOTS];
    logic [31:0]      paddr_reg  [SLOTS];
    logic [31:0]      laddr_reg  [SLOTS];

    logic [15:0] first_reg, end_reg, next_port_reg;
    logic [2:0]  rq_reg;
    logic [3:0]  rs_reg;
    logic [15:0] rlp_reg, rrp_reg;
    logic [31:0] rra_reg, rla_reg;
    logic [SW-1:0] idx_reg;
    logic [15:0] cand_reg, start_reg;

    logic [SW-1:0] tgt;
    logic [15:0]   cand_inc, cand_wrap, port_try;
    logic          tgt_in;

    assign tgt_in   = ({4'd0, rs_reg} < 8'(SLOTS));
    assign tgt      = rs_reg[SW-1:0];
    assign cand_inc = cand_reg + 16'd1;
    assign cand_wrap = (cand_inc >= end_reg) ? first_reg : cand_inc;
    assign port_try = cmd.use_req ? rlp_reg : cand_reg;

    always_comb
    begin
        logic m;
        m = open_reg[idx_reg] && (idx_reg != tgt) && (lport_reg[idx_reg] == port_try);
        stat.req       = rq_reg;
        stat.slot_ok   = tgt_in;
        stat.tgt_open  = tgt_in && open_reg[tgt];
        stat.tgt_init  = mode_reg[tgt][0];
        stat.scan_last = (32'(idx_reg) == SLOTS - 1);
        stat.cand_zero = (port_try == 16'd0);
        stat.cand_back = (cand_wrap == start_reg);
        if (rq_reg == REQ_RECV)
            stat.scan_hit = open_reg[idx_reg] && (lport_reg[idx_reg] == rlp_reg) &&
                (mode_reg[idx_reg][2] || !mode_reg[idx_reg][1] ||
                 (pport_reg[idx_reg] == rrp_reg && paddr_reg[idx_reg] == rra_reg));
        else
            stat.scan_hit = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= EPH_FIRST_RST;
            end_reg       <= EPH_END_RST;
            next_port_reg <= EPH_FIRST_RST;
            open_reg      <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i]  <= '0;
                lport_reg[i] <= '0;
                pport_reg[i] <= '0;
                paddr_reg[i] <= '0;
                laddr_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == 1'(CFG_FIRST))
                first_reg <= cfg_data;
            if (cfg_we && cfg_index == 1'(CFG_END))
                end_reg <= cfg_data;
            if (cmd.cand_init)
                next_port_reg <= (next_port_reg >= end_reg) ? first_reg : next_port_reg;
            if (cmd.cand_step)
                next_port_reg <= cand_wrap;
            if (cmd.commit)
            begin
                logic [2:0] md;
                md = mode_reg[tgt];
                unique case (rq_reg)
                    REQ_OPEN:
                    begin
                        open_reg[tgt] <= 1'b1;
                        mode_reg[tgt] <= MODE_INIT;
                    end
                    REQ_CLOSE:
                        open_reg[tgt] <= 1'b0;
                    REQ_BIND:
                    begin
                        lport_reg[tgt] <= port_try;
                        mode_reg[tgt]  <= md & ~MODE_INIT;
                    end
                    REQ_CONNECT:
                    begin
                        lport_reg[tgt] <= port_try;
                        pport_reg[tgt] <= rrp_reg;
                        paddr_reg[tgt] <= rra_reg;
                        laddr_reg[tgt] <= rla_reg;
                        mode_reg[tgt]  <= (md | MODE_CONN) & ~MODE_INIT;
                    end
                    REQ_LISTEN:
                    begin
                        lport_reg[tgt] <= port_try;
                        mode_reg[tgt]  <= (md | MODE_LISTEN) & ~MODE_INIT;
                    end
                    default:
                        ;
                endcase
                if (!cmd.use_req && (rq_reg == REQ_BIND || rq_reg == REQ_CONNECT ||
                                     rq_reg == REQ_LISTEN))
                    next_port_reg <= cand_inc;
            end
            if (cmd.fail_bind)
                lport_reg[tgt] <= 16'd0;
            if (cmd.recv_hit && mode_reg[idx_reg][2])
            begin
                pport_reg[idx_reg] <= rrp_reg;
                paddr_reg[idx_reg] <= rra_reg;
                if (laddr_reg[idx_reg] == 32'd0)
                    laddr_reg[idx_reg] <= rla_reg;
                mode_reg[idx_reg] <= (mode_reg[idx_reg] | MODE_CONN) & ~MODE_LISTEN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_reg  <= req_type;
            rs_reg  <= slot;
            rlp_reg <= local_port;
            rrp_reg <= remote_port;
            rra_reg <= remote_addr;
            rla_reg <= local_addr;
        end
        if (cmd.scan_clr)
            idx_reg <= '0;
        else if (cmd.scan_step)
            idx_reg <= idx_reg + SW'(1);
        if (cmd.cand_init)
        begin
            cand_reg  <= (next_port_reg >= end_reg) ? first_reg : next_port_reg;
            start_reg <= (next_port_reg >= end_reg) ? first_reg : next_port_reg;
        end
        else if (cmd.cand_step)
            cand_reg <= cand_wrap;
    end

    // result register; commit writes land at the same edge, so table reads see old values
    always_ff @(posedge clk)
    begin
        if (cmd.ignore)
        begin
            status <= ST_IGNORED; hit_slot <= rs_reg; reply_sent <= 1'b0;
            bound_port <= '0; peer_port <= '0; peer_addr <= '0; pass_source <= 1'b0;
        end
        else if (cmd.recv_miss)
        begin
            status <= ST_NOMATCH; hit_slot <= '0; reply_sent <= 1'b0;
            bound_port <= '0; peer_port <= '0; peer_addr <= '0; pass_source <= 1'b0;
        end
        else if (cmd.recv_hit)
        begin
            status     <= ST_OK;
            hit_slot   <= 4'(idx_reg);
            bound_port <= lport_reg[idx_reg];
            if (mode_reg[idx_reg][2])
            begin
                reply_sent <= 1'b1; peer_port <= rrp_reg; peer_addr <= rra_reg;
                pass_source <= 1'b0;
            end
            else
            begin
                reply_sent <= 1'b0; peer_port <= pport_reg[idx_reg];
                peer_addr <= paddr_reg[idx_reg]; pass_source <= !mode_reg[idx_reg][1];
            end
        end
        else if (cmd.refuse_open || cmd.fail_bind)
        begin
            status <= ST_REFUSED; hit_slot <= rs_reg; reply_sent <= 1'b0;
            bound_port <= cmd.fail_bind ? 16'd0 : lport_reg[tgt];
            peer_port <= pport_reg[tgt]; peer_addr <= paddr_reg[tgt];
            pass_source <= 1'b0;
        end
        else if (cmd.commit)
        begin
            hit_slot <= rs_reg; pass_source <= 1'b0;
            status <= ST_OK; reply_sent <= 1'b0;
            bound_port <= lport_reg[tgt]; peer_port <= pport_reg[tgt];
            peer_addr <= paddr_reg[tgt];
            unique case (rq_reg)
                REQ_BIND:
                begin
                    bound_port <= port_try; reply_sent <= 1'b1;
                end
                REQ_CONNECT:
                begin
                    bound_port <= port_try; reply_sent <= 1'b1;
                    peer_port <= rrp_reg; peer_addr <= rra_reg;
                    status <= (rla_reg == 32'd0) ? ST_REFUSED : ST_OK;
                end
                REQ_LISTEN:
                    bound_port <= port_try;
                default:
                    ;
            endcase
        end
    end

endmodule

>>> sv/udpd_ctrl.sv
// udpd_ctrl: request sequencer; drives scans, allocation and output handshake.
// Depends on udpd_pkg.
module udpd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  udpd_pkg::stat_t stat,
    output udpd_pkg::cmd_t  cmd
);
    import udpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN_RX, S_SCAN_PORT, S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   taken_reg;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.use_req = (stat.req != REQ_RECV) && taken_reg;
        cmd.load = in_valid && in_ready;
        unique case (state_reg)
            S_DECODE:
            begin
                cmd.scan_clr = 1'b1;
                if (stat.req == REQ_RECV)
                    ;
                else if (!stat.slot_ok || stat.req > REQ_RECV)
                    cmd.ignore = 1'b1;
                else if (stat.req == REQ_OPEN)
                begin
                    if (stat.tgt_open) cmd.refuse_open = 1'b1;
                    else cmd.commit = 1'b1;
                end
                else if (stat.req == REQ_CLOSE)
                begin
                    if (stat.tgt_open) cmd.commit = 1'b1;
                    else cmd.ignore = 1'b1;
                end
                else if (!stat.tgt_open || !stat.tgt_init)
                    cmd.ignore = 1'b1;
            end
            S_SCAN_RX:
            begin
                if (stat.scan_hit) cmd.recv_hit = 1'b1;
                else if (stat.scan_last) cmd.recv_miss = 1'b1;
                else cmd.scan_step = 1'b1;
            end
            S_SCAN_PORT:
            begin
                if (stat.cand_zero || stat.scan_hit)
                begin
                    cmd.scan_clr = 1'b1;
                    if (taken_reg)
                    begin
                        if (stat.cand_zero) cmd.cand_init = 1'b1;
                        else cmd.fail_bind = 1'b1;
                    end
                    else if (stat.cand_back)
                    begin
                        cmd.fail_bind = 1'b1;
                        cmd.cand_step = 1'b1;
                    end
                    else cmd.cand_step = 1'b1;
                end
                else if (stat.scan_last) cmd.commit = 1'b1;
                else cmd.scan_step = 1'b1;
            end
            default:
                ;
        endcase
    end

    // taken_reg: request's own port is being tried; cleared when it is zero or the request ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            taken_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (cmd.load) state_reg <= S_DECODE;
                S_DECODE:
                begin
                    if (stat.req == REQ_RECV) state_reg <= S_SCAN_RX;
                    else if (cmd.ignore || cmd.commit || cmd.refuse_open)
                        state_reg <= S_DONE;
                    else
                    begin
                        state_reg <= S_SCAN_PORT;
                        taken_reg <= 1'b1;
                    end
                end
                S_SCAN_RX:
                    if (cmd.recv_hit || cmd.recv_miss) state_reg <= S_DONE;
                S_SCAN_PORT:
                begin
                    if (cmd.commit || cmd.fail_bind) state_reg <= S_DONE;
                    if (taken_reg && stat.cand_zero && !cmd.fail_bind)
                        taken_reg <= 1'b0;
                    if (cmd.commit || cmd.fail_bind) taken_reg <= 1'b0;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.commit, cmd.ignore, cmd.recv_hit, cmd.recv_miss, cmd.refuse_open}))
        else $error("conflicting outcome commands");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE && !out_valid_reg)
        else $error("request taken while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid_reg)
        else $error("result not presented");

endmodule
